@@ rtl/core/direction_program_editor_player_macros.svh @@
// ----------------------------------------------------------------------------
// direction_program_editor_player_macros
// Assertion shorthands used by dpep_seq.
// ----------------------------------------------------------------------------
`ifndef DIRECTION_PROGRAM_EDITOR_PLAYER_MACROS_SVH
`define DIRECTION_PROGRAM_EDITOR_PLAYER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define DPEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPEP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/dpep_pkg.sv @@
// ----------------------------------------------------------------------------
// dpep_pkg
// Shared widths, codes and result type of the direction program editor/player.
// ----------------------------------------------------------------------------
package dpep_pkg;

	localparam int DEF_PROGRAM_DEPTH = 32;
	localparam int DEF_WINDOW_COLS   = 16;

	localparam int KIND_W    = 3;
	localparam int CMD_W     = 2;
	localparam int STEPS_W   = 16;
	localparam int POS_W     = 6;
	localparam int CFG_IDX_W = 1;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BACK   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_FWD    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RUN    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_STEP   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_STOP   = 3'd6;

	// stored directions
	localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BACK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LEFT    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RIGHT   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PIVOT_COUNT    = 1'b1;

	localparam logic [STEPS_W-1:0] STRAIGHT_COUNT_RST = 16'd200;
	localparam logic [STEPS_W-1:0] PIVOT_COUNT_RST    = 16'd100;

	typedef struct packed {
		logic               accepted;
		logic               move_issue;
		logic               left_reverse;
		logic               right_reverse;
		logic [STEPS_W-1:0] move_steps;
		logic               motor_stop;
		logic               is_running;
		logic [POS_W-1:0]   cursor_pos;
		logic [POS_W-1:0]   prog_length;
		logic [POS_W-1:0]   window_start;
	} result_t;

endpackage

@@ rtl/core/dpep_intf.sv @@
// ----------------------------------------------------------------------------
// dpep_intf
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface dpep_in_if import dpep_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CMD_W-1:0]  command;

	modport source (output valid, kind, command, input ready);
	modport sink (input valid, kind, command, output ready);
endinterface

interface dpep_out_if import dpep_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               accepted;
	logic               move_issue;
	logic               left_reverse;
	logic               right_reverse;
	logic [STEPS_W-1:0] move_steps;
	logic               motor_stop;
	logic               is_running;
	logic [POS_W-1:0]   cursor_pos;
	logic [POS_W-1:0]   prog_length;
	logic [POS_W-1:0]   window_start;

	modport source (output valid, accepted, move_issue, left_reverse, right_reverse,
		move_steps, motor_stop, is_running, cursor_pos, prog_length, window_start,
		input ready);
	modport sink (input valid, accepted, move_issue, left_reverse, right_reverse,
		move_steps, motor_stop, is_running, cursor_pos, prog_length, window_start,
		output ready);
endinterface

@@ rtl/core/dpep_ram.sv @@
// ----------------------------------------------------------------------------
// dpep_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpep_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/dpep_window.sv @@
// ----------------------------------------------------------------------------
// dpep_window
// Start index of the display window that follows the cursor.
// ----------------------------------------------------------------------------
module dpep_window import dpep_pkg::*; #(
	parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
	parameter int WINDOW_COLS   = DEF_WINDOW_COLS
) (
	input  logic [$clog2(PROGRAM_DEPTH+1)-1:0] cursor,
	input  logic [$clog2(PROGRAM_DEPTH+1)-1:0] length,
	output logic [POS_W-1:0]                   window_start
);

	localparam int CW   = $clog2(PROGRAM_DEPTH + 1);
	localparam int WCW  = $clog2(WINDOW_COLS + 1);
	localparam int WW   = (CW > WCW) ? CW : WCW;
	localparam int HALF = WINDOW_COLS / 2;

	logic [WW-1:0] cur_w;
	logic [WW-1:0] len_w;
	logic [WW-1:0] win_w;

	always_comb begin
		cur_w = WW'(cursor);
		len_w = WW'(length);
		priority if (len_w < WW'(WINDOW_COLS) || cur_w < WW'(HALF)) begin
			win_w = '0;
		end else if ((len_w - cur_w) < WW'(HALF)) begin
			win_w = len_w - WW'(WINDOW_COLS - 1);
		end else begin
			win_w = cur_w - WW'(HALF);
		end
		window_start = POS_W'(win_w);
	end

endmodule

@@ rtl/core/dpep_seq.sv @@
// ----------------------------------------------------------------------------
// dpep_seq
// Editor/player sequencer: decodes one request, drives the command RAM
// through its single read and write port, and shifts entries down on delete.
// ----------------------------------------------------------------------------
`include "direction_program_editor_player_macros.svh"

module dpep_seq import dpep_pkg::*; #(
	parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
	parameter int WINDOW_COLS   = DEF_WINDOW_COLS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [KIND_W-1:0]  req_kind,
	input  logic [CMD_W-1:0]   req_cmd,
	input  logic [STEPS_W-1:0] straight_count,
	input  logic [STEPS_W-1:0] pivot_count,
	output logic               res_valid,
	input  logic               res_take,
	output result_t            res
);

	localparam int AW = $clog2(PROGRAM_DEPTH);
	localparam int CW = $clog2(PROGRAM_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         state_q;
	logic [KIND_W-1:0]  kind_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      length_q;
	logic               running_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic               pend_q;
	logic               acc_q;
	logic               move_q;
	logic               lrev_q;
	logic               rrev_q;
	logic [STEPS_W-1:0] steps_q;
	logic               stop_q;

	logic               cur_at_end;
	logic               full;
	logic [CW:0]        cur_inc;
	logic [CW-1:0]      wr_sel;
	logic               do_write;
	logic               shift_rd;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [CMD_W-1:0]   ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [CMD_W-1:0]   ram_rdata;
	logic [POS_W-1:0]   win;

	always_comb begin
		cur_at_end = cursor_q >= length_q;
		full       = length_q == CW'(PROGRAM_DEPTH);
		cur_inc    = {1'b0, cursor_q} + 1'b1;
		// append lands at the end of the list, otherwise overwrite at the cursor
		wr_sel     = cur_at_end ? length_q : cursor_q;
		do_write   = (state_q == ST_EXEC) && (kind_q == KIND_WRITE) && !running_q &&
			!(cur_at_end && full);
		shift_rd   = (state_q == ST_SHIFT) && (rd_q < length_q);

		ram_we     = do_write || ((state_q == ST_SHIFT) && pend_q);
		ram_waddr  = (state_q == ST_SHIFT) ? wr_q[AW-1:0] : wr_sel[AW-1:0];
		ram_wdata  = (state_q == ST_SHIFT) ? ram_rdata : cmd_q;
		if (state_q == ST_SHIFT) begin
			ram_raddr = rd_q[AW-1:0];
		end else if (kind_q == KIND_RUN) begin
			ram_raddr = '0;
		end else begin
			ram_raddr = cursor_q[AW-1:0];
		end
	end

	dpep_ram #(
		.WIDTH (CMD_W),
		.DEPTH (PROGRAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dpep_window #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.WINDOW_COLS   (WINDOW_COLS)
	) u_window (
		.cursor       (cursor_q),
		.length       (length_q),
		.window_start (win)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cursor_q  <= '0;
			length_q  <= '0;
			running_q <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					unique case (kind_q)
						KIND_WRITE: begin
							if (do_write) begin
								if (cur_at_end) begin
									length_q <= length_q + CW'(1);
								end
								cursor_q <= wr_sel + CW'(1);
							end
						end
						KIND_DELETE: begin
							if (!running_q && length_q != '0) begin
								state_q <= ST_SHIFT;
								pend_q  <= 1'b0;
							end
						end
						KIND_BACK: begin
							if (!running_q && cursor_q != '0) begin
								cursor_q <= cursor_q - CW'(1);
							end
						end
						KIND_FWD: begin
							if (!running_q && cursor_q < length_q) begin
								cursor_q <= cursor_q + CW'(1);
							end
						end
						KIND_RUN: begin
							cursor_q <= '0;
							if (length_q == '0) begin
								running_q <= 1'b0;
							end else begin
								running_q <= 1'b1;
								state_q   <= ST_FETCH;
							end
						end
						KIND_STEP: begin
							if (running_q) begin
								if (cur_at_end) begin
									running_q <= 1'b0;
								end else begin
									state_q <= ST_FETCH;
								end
							end
						end
						KIND_STOP: begin
							running_q <= 1'b0;
						end
						default: begin
						end
					endcase
				end
				ST_SHIFT: begin
					// read runs one entry ahead of the write through the registered port
					pend_q <= shift_rd;
					if (!shift_rd && !pend_q) begin
						length_q <= length_q - CW'(1);
						if (cursor_q == length_q) begin
							cursor_q <= length_q - CW'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_FETCH: begin
					cursor_q <= cursor_q + CW'(1);
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload side: no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kind_q  <= req_kind;
				cmd_q   <= req_cmd;
				acc_q   <= 1'b0;
				move_q  <= 1'b0;
				lrev_q  <= 1'b0;
				rrev_q  <= 1'b0;
				steps_q <= '0;
				stop_q  <= 1'b0;
			end
			ST_EXEC: begin
				rd_q <= (cur_inc < {1'b0, length_q}) ? cur_inc[CW-1:0] : length_q;
				wr_q <= cursor_q;
				unique case (kind_q)
					KIND_WRITE:  acc_q <= do_write;
					KIND_DELETE: acc_q <= !running_q && length_q != '0;
					KIND_BACK:   acc_q <= !running_q;
					KIND_FWD:    acc_q <= !running_q;
					KIND_RUN: begin
						acc_q  <= 1'b1;
						stop_q <= length_q == '0;
					end
					KIND_STEP: begin
						acc_q  <= running_q;
						stop_q <= running_q && cur_at_end;
					end
					KIND_STOP: begin
						acc_q  <= 1'b1;
						stop_q <= 1'b1;
					end
					default: acc_q <= 1'b0;
				endcase
			end
			ST_SHIFT: begin
				if (shift_rd) begin
					rd_q <= rd_q + CW'(1);
				end
				if (pend_q) begin
					wr_q <= wr_q + CW'(1);
				end
			end
			ST_FETCH: begin
				move_q <= 1'b1;
				unique case (ram_rdata)
					CMD_FORWARD: begin
						lrev_q  <= 1'b0;
						rrev_q  <= 1'b0;
						steps_q <= straight_count;
					end
					CMD_BACK: begin
						lrev_q  <= 1'b1;
						rrev_q  <= 1'b1;
						steps_q <= straight_count;
					end
					CMD_LEFT: begin
						lrev_q  <= 1'b1;
						rrev_q  <= 1'b0;
						steps_q <= pivot_count;
					end
					CMD_RIGHT: begin
						lrev_q  <= 1'b0;
						rrev_q  <= 1'b1;
						steps_q <= pivot_count;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign req_ready = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;

	always_comb begin
		res.accepted      = acc_q;
		res.move_issue    = move_q;
		res.left_reverse  = lrev_q;
		res.right_reverse = rrev_q;
		res.move_steps    = steps_q;
		res.motor_stop    = stop_q;
		res.is_running    = running_q;
		res.cursor_pos    = POS_W'(cursor_q);
		res.prog_length   = POS_W'(length_q);
		res.window_start  = win;
	end

	`DPEP_ASSERT_IMP(a_len_bound, 1'b1, length_q <= CW'(PROGRAM_DEPTH), "length past depth")
	`DPEP_ASSERT_IMP(a_cur_bound, 1'b1, cursor_q <= length_q, "cursor past length")
	`DPEP_ASSERT_IMP(a_shift_idle, state_q == ST_SHIFT, !running_q, "shift during playback")
	`DPEP_ASSERT_IMP(a_move_acc, res_valid && res.move_issue, res.accepted && res.is_running,
		"move without playback")
	`DPEP_ASSERT_NXT(a_fetch_done, state_q == ST_FETCH, state_q == ST_DONE && move_q,
		"fetch did not issue move")

endmodule

@@ rtl/core/direction_program_editor_player.sv @@
// ----------------------------------------------------------------------------
// direction_program_editor_player
// Direction program editor and player with configurable step counts.
// ----------------------------------------------------------------------------
// One request is taken at a time; the next is accepted as soon as the
// sequencer is back in idle, even while the previous result still sits in
// the output register. Writes, cursor moves, stop, refused requests and a
// run or step that issues no move go from the execute state straight to the
// done state; a run or step that issues a move passes through the fetch
// state between them, since the command is read from the program RAM through
// its registered port. Delete shifts the later entries down one per cycle
// through the RAM's read and write ports in the shift state before done.
// The sequencer returns to idle in the cycle after handing over its result.
// No clearing pass runs after reset; entries are only read once written.
module direction_program_editor_player import dpep_pkg::*; #(
	parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
	parameter int WINDOW_COLS   = DEF_WINDOW_COLS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [STEPS_W-1:0]   cfg_wdata,
	dpep_in_if.sink              request,
	dpep_out_if.source           response
);

	logic [STEPS_W-1:0] straight_count_q;
	logic [STEPS_W-1:0] pivot_count_q;
	logic               res_valid;
	logic               res_take;
	result_t            res;
	logic               out_valid_q;
	result_t            out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_count_q <= STRAIGHT_COUNT_RST;
			pivot_count_q    <= PIVOT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STRAIGHT_COUNT: straight_count_q <= cfg_wdata;
				REG_PIVOT_COUNT:    pivot_count_q    <= cfg_wdata;
			endcase
		end
	end

	dpep_seq #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.WINDOW_COLS   (WINDOW_COLS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (request.valid),
		.req_ready      (request.ready),
		.req_kind       (request.kind),
		.req_cmd        (request.command),
		.straight_count (straight_count_q),
		.pivot_count    (pivot_count_q),
		.res_valid      (res_valid),
		.res_take       (res_take),
		.res            (res)
	);

	// output register frees the sequencer while a result waits
	assign res_take = res_valid && (!out_valid_q || response.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign response.valid         = out_valid_q;
	assign response.accepted      = out_q.accepted;
	assign response.move_issue    = out_q.move_issue;
	assign response.left_reverse  = out_q.left_reverse;
	assign response.right_reverse = out_q.right_reverse;
	assign response.move_steps    = out_q.move_steps;
	assign response.motor_stop    = out_q.motor_stop;
	assign response.is_running    = out_q.is_running;
	assign response.cursor_pos    = out_q.cursor_pos;
	assign response.prog_length   = out_q.prog_length;
	assign response.window_start  = out_q.window_start;

endmodule
